// File: design/kf2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_pkg
// Shared types, constants and saturation helpers for the two-state filter.
// ----------------------------------------------------------------------------
package kf2_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int NUM_REGS   = 8;
  localparam int IDX_WIDTH  = 3;
  localparam int QUO_WIDTH  = DATA_WIDTH + FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  localparam data_t MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [IDX_WIDTH-1:0] REG_TPP = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_TPV = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_TVP = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_TVV = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_QPP = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_QPV = 3'd5;
  localparam logic [IDX_WIDTH-1:0] REG_QVV = 3'd6;
  localparam logic [IDX_WIDTH-1:0] REG_R   = 3'd7;

  // Multiplier-accumulator opcode
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,  // acc = a*b
    OP_MAC  = 2'd1,  // acc = sat(acc + a*b)
    OP_ADD  = 2'd2,  // acc = sat(acc + b)
    OP_SUB  = 2'd3   // acc = sat(b - a*c)   (b minus product)
  } mac_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

  // Saturating sum of two data words
  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    begin
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) sat_add = s[DATA_WIDTH] ? MINV : MAXV;
      else sat_add = s[DATA_WIDTH-1:0];
    end
  endfunction

  function automatic data_t sat_sub(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    begin
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) sat_sub = s[DATA_WIDTH] ? MINV : MAXV;
      else sat_sub = s[DATA_WIDTH-1:0];
    end
  endfunction

  // Fixed-point rescale of a full product: floor shift, then saturate
  function automatic data_t prod_scale(input prod_t p);
    prod_t sh;
    begin
      sh = p >>> FRAC_BITS;
      if (sh > prod_t'(MAXV)) prod_scale = MAXV;
      else if (sh < prod_t'(MINV)) prod_scale = MINV;
      else prod_scale = sh[DATA_WIDTH-1:0];
    end
  endfunction

  function automatic logic [31:0] out_s(input data_t v);
    prod_t w;
    begin
      w = prod_t'(v);
      if (w > 64'sd2147483647) out_s = 32'h7fff_ffff;
      else if (w < -64'sd2147483648) out_s = 32'h8000_0000;
      else out_s = w[31:0];
    end
  endfunction

  function automatic logic [30:0] out_u(input data_t v);
    prod_t w;
    begin
      w = prod_t'(v);
      if (w > 64'sd2147483647) out_u = 31'h7fff_ffff;
      else if (w < 0) out_u = '0;
      else out_u = w[30:0];
    end
  endfunction

  function automatic data_t take_s(input logic [31:0] v);
    prod_t w;
    begin
      w = prod_t'($signed(v));
      if (w > prod_t'(MAXV)) take_s = MAXV;
      else if (w < prod_t'(MINV)) take_s = MINV;
      else take_s = w[DATA_WIDTH-1:0];
    end
  endfunction

  function automatic data_t take_u(input logic [30:0] v);
    prod_t w;
    begin
      w = prod_t'({1'b0, v});
      if (w > prod_t'(MAXV)) take_u = MAXV;
      else take_u = w[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

// File: design/kf2_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_mac
// Shared multiplier with registered product and saturating accumulator.
// ----------------------------------------------------------------------------
module kf2_mac import kf2_pkg::*; (
  input  logic    clk,
  input  logic    go,
  input  mac_op_t op,
  input  data_t   opa,
  input  data_t   opb,
  input  data_t   addend,
  output data_t   acc
);

  // stage 1: product register
  prod_t   prod_r;
  mac_op_t op_r;
  data_t   add_r;
  logic    go_r;
  data_t   acc_r;
  data_t   acc_nxt;
  data_t   pq;

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    op_r   <= op;
    add_r  <= addend;
    go_r   <= go;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    pq      = prod_scale(prod_r);
    acc_nxt = acc_r;
    if (go_r) begin
      case (op_r)
        OP_LOAD: acc_nxt = pq;
        OP_MAC:  acc_nxt = sat_add(acc_r, pq);
        OP_ADD:  acc_nxt = sat_add(acc_r, add_r);
        OP_SUB:  acc_nxt = sat_sub(add_r, pq);
        default: acc_nxt = acc_r;
      endcase
    end
  end

  // step result, valid in the write-back cycle
  assign acc = acc_nxt;

endmodule

// File: design/kf2_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_div
// Restoring divider: (|num| << FRAC_BITS) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kf2_div import kf2_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  data_t num,
  input  data_t den,
  output logic  busy,
  output data_t quo
);

  localparam int CW = $clog2(QUO_WIDTH + 1);

  logic [QUO_WIDTH-1:0]  dvd_r;
  logic [QUO_WIDTH-1:0]  q_r;
  logic [DATA_WIDTH:0]   rem_r;
  logic [DATA_WIDTH-1:0] den_r;
  logic                  neg_r;
  logic [CW-1:0]         cnt_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] mag;

  assign mag   = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
  assign trial = {rem_r[DATA_WIDTH-1:0], dvd_r[QUO_WIDTH-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(QUO_WIDTH);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
    if (start) begin
      dvd_r <= {mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
      den_r <= den;
      neg_r <= num[DATA_WIDTH-1];
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_r << 1;
      if (!diff[DATA_WIDTH]) begin
        rem_r <= diff;
        q_r   <= {q_r[QUO_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[QUO_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt_r != '0);

  always_comb begin
    if (q_r[QUO_WIDTH-1:DATA_WIDTH-1] != '0) quo = neg_r ? MINV : MAXV;
    else if (neg_r) quo = -$signed(q_r[DATA_WIDTH-1:0]);
    else quo = q_r[DATA_WIDTH-1:0];
  end

endmodule

// File: design/kalman_filter_2state_1meas_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_2state_1meas_unit
// Two-state Kalman filter on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  in_     | in  | in_valid/in_stall  | mode, measurement, initial state
//  out_    | out | out_valid/out_stall| estimate, covariance, skip flag
//  cfg_    | in  | cfg_valid/cfg_ready| register index, data
//
// A load word passes from acceptance through the hand-off state into the
// output register. A measurement word walks 32 multiply/add steps (an issue
// and a write-back phase each, through the registered multiplier) plus two
// divides for the gains; when the correction is skipped it stops after the
// innovation step. The shared multiplier and bit-serial divider set its pace.
// Reset restores the default matrices and state. A result waits in the
// output register while out_stall is high; the next word is taken meanwhile
// and, once finished, holds in the hand-off state until the register frees.
// ----------------------------------------------------------------------------
module kalman_filter_2state_1meas_unit import kf2_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_measurement,
  input  logic [31:0] in_init_pos,
  input  logic [31:0] in_init_vel,
  input  logic [30:0] in_init_p00,
  input  logic [31:0] in_init_p01,
  input  logic [30:0] in_init_p11,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_est_pos,
  output logic [31:0] out_est_vel,
  output logic [30:0] out_var_pos,
  output logic [31:0] out_cov_pos_vel,
  output logic [30:0] out_var_vel,
  output logic        out_gain_skipped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  // Scratch register file indexes
  typedef enum logic [4:0] {
    V_A, V_B, V_C, V_D, V_QPP, V_QPV, V_QVV, V_R,
    V_X, V_V, V_P00, V_P01, V_P11,
    V_X0, V_X1, V_M00, V_M01, V_M10, V_M11,
    V_PP00, V_PP01, V_PP11, V_S, V_K0, V_K1, V_IN, V_Z, V_ZERO
  } var_t;

  // One microcode step: acc op with operands, optional write of result
  typedef struct packed {
    mac_op_t op;
    var_t    a;
    var_t    b;
    logic    wr;
    var_t    dst;
  } ustep_t;

  function automatic ustep_t ucode(input logic [5:0] i);
    ustep_t u;
    begin
      u = '{OP_LOAD, V_ZERO, V_ZERO, 1'b0, V_ZERO};
      case (i)
        6'd0:  u = '{OP_LOAD, V_A, V_X, 1'b0, V_ZERO};
        6'd1:  u = '{OP_MAC,  V_B, V_V, 1'b1, V_X0};
        6'd2:  u = '{OP_LOAD, V_C, V_X, 1'b0, V_ZERO};
        6'd3:  u = '{OP_MAC,  V_D, V_V, 1'b1, V_X1};
        6'd4:  u = '{OP_LOAD, V_A, V_P00, 1'b0, V_ZERO};
        6'd5:  u = '{OP_MAC,  V_B, V_P01, 1'b1, V_M00};
        6'd6:  u = '{OP_LOAD, V_A, V_P01, 1'b0, V_ZERO};
        6'd7:  u = '{OP_MAC,  V_B, V_P11, 1'b1, V_M01};
        6'd8:  u = '{OP_LOAD, V_C, V_P00, 1'b0, V_ZERO};
        6'd9:  u = '{OP_MAC,  V_D, V_P01, 1'b1, V_M10};
        6'd10: u = '{OP_LOAD, V_C, V_P01, 1'b0, V_ZERO};
        6'd11: u = '{OP_MAC,  V_D, V_P11, 1'b1, V_M11};
        6'd12: u = '{OP_LOAD, V_M00, V_A, 1'b0, V_ZERO};
        6'd13: u = '{OP_MAC,  V_M01, V_B, 1'b0, V_ZERO};
        6'd14: u = '{OP_ADD,  V_ZERO, V_QPP, 1'b1, V_PP00};
        6'd15: u = '{OP_LOAD, V_M00, V_C, 1'b0, V_ZERO};
        6'd16: u = '{OP_MAC,  V_M01, V_D, 1'b0, V_ZERO};
        6'd17: u = '{OP_ADD,  V_ZERO, V_QPV, 1'b1, V_PP01};
        6'd18: u = '{OP_LOAD, V_M10, V_C, 1'b0, V_ZERO};
        6'd19: u = '{OP_MAC,  V_M11, V_D, 1'b0, V_ZERO};
        6'd20: u = '{OP_ADD,  V_ZERO, V_QVV, 1'b1, V_PP11};
        6'd21: u = '{OP_LOAD, V_ZERO, V_ZERO, 1'b0, V_ZERO};
        6'd22: u = '{OP_ADD,  V_ZERO, V_PP00, 1'b0, V_ZERO};
        6'd23: u = '{OP_ADD,  V_ZERO, V_R, 1'b1, V_S};
        // innovation: Z - X0, computed as sat(Z - 1.0*X0), written to V_IN
        6'd24: u = '{OP_SUB,  V_X0, V_Z, 1'b1, V_IN};
        // after divides (K0, K1 ready)
        6'd25: u = '{OP_LOAD, V_K0, V_IN, 1'b0, V_ZERO};
        6'd26: u = '{OP_ADD,  V_ZERO, V_X0, 1'b1, V_X};
        6'd27: u = '{OP_LOAD, V_K1, V_IN, 1'b0, V_ZERO};
        6'd28: u = '{OP_ADD,  V_ZERO, V_X1, 1'b1, V_V};
        6'd29: u = '{OP_SUB,  V_K0, V_PP00, 1'b1, V_P00};
        6'd30: u = '{OP_SUB,  V_K0, V_PP01, 1'b1, V_P01};
        6'd31: u = '{OP_SUB,  V_K1, V_PP11, 1'b1, V_P11};
        default: u = '{OP_LOAD, V_ZERO, V_ZERO, 1'b0, V_ZERO};
      endcase
      ucode = u;
    end
  endfunction

  localparam logic [5:0] PC_PRE_DIV  = 6'd24;
  localparam logic [5:0] PC_POST_DIV = 6'd25;
  localparam logic [5:0] PC_LAST     = 6'd31;

  state_t state_r, state_nxt;
  data_t  rf_r [28];
  logic [5:0] pc_r, pc_nxt;
  logic       ph_r, ph_nxt;      // 0 issue, 1 write-back
  logic       dsel_r, dsel_nxt;  // which gain is being divided
  logic       skip_r, skip_nxt;
  logic       dstart_r;
  logic       dbusy;
  data_t      quo;
  data_t      acc;
  ustep_t     u;
  logic       mac_go;

  // output register
  logic        ovalid_r;
  logic [31:0] opos_r, ovel_r, ocov_r;
  logic [30:0] ovarp_r, ovarv_r;
  logic        oskip_r;
  logic        oload;

  assign u = ucode(pc_r);
  // Special case: for OP_SUB the b operand is the addend, and the multiply
  // uses a times c: 1.0 at the innovation, PP01 at the last step, else b.
  data_t mop_b;
  always_comb begin
    mop_b = rf_r[u.b];
    if (u.op == OP_SUB) begin
      if (pc_r == PC_PRE_DIV) mop_b = data_t'(1) <<< FRAC_BITS;
      else if (pc_r == PC_LAST) mop_b = rf_r[V_PP01];
      else mop_b = rf_r[u.b];
    end
  end

  assign mac_go = (state_r == ST_MAC) && !ph_r;

  kf2_mac u_mac (
    .clk    (clk),
    .go     (mac_go),
    .op     (u.op),
    .opa    (rf_r[u.a]),
    .opb    (mop_b),
    .addend (rf_r[u.b]),
    .acc    (acc)
  );

  kf2_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart_r),
    .num   (dsel_r ? rf_r[V_PP01] : rf_r[V_PP00]),
    .den   (rf_r[V_S]),
    .busy  (dbusy),
    .quo   (quo)
  );

  logic in_acc, out_acc;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = ovalid_r;
  // hand-off into the output register once it is free or being emptied
  assign oload     = (state_r == ST_OUT) && (!ovalid_r || out_acc);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ph_nxt    = ph_r;
    dsel_nxt  = dsel_r;
    skip_nxt  = skip_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pc_nxt   = '0;
          ph_nxt   = 1'b0;
          skip_nxt = 1'b0;
          state_nxt = in_mode ? ST_OUT : ST_MAC;
        end
      end
      ST_MAC: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (pc_r == PC_PRE_DIV) begin
            if (!rf_r[V_S][DATA_WIDTH-1] && rf_r[V_S] != '0) begin
              state_nxt = ST_DIV;
              dsel_nxt  = 1'b0;
            end else begin
              skip_nxt  = 1'b1;
              state_nxt = ST_OUT;
            end
            pc_nxt = PC_POST_DIV;
          end else if (pc_r == PC_LAST) begin
            state_nxt = ST_OUT;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (!dstart_r && !dbusy) begin
          if (dsel_r) state_nxt = ST_MAC;
          dsel_nxt = 1'b1;
        end
      end
      ST_OUT: begin
        if (oload) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (oload) begin
      ovalid_r <= 1'b1;
    end else if (out_acc) begin
      ovalid_r <= 1'b0;
    end
    if (oload) begin
      opos_r  <= out_s(rf_r[V_X]);
      ovel_r  <= out_s(rf_r[V_V]);
      ovarp_r <= out_u(rf_r[V_P00]);
      ocov_r  <= out_s(rf_r[V_P01]);
      ovarv_r <= out_u(rf_r[V_P11]);
      oskip_r <= skip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pc_r     <= '0;
      ph_r     <= 1'b0;
      dsel_r   <= 1'b0;
      skip_r   <= 1'b0;
      dstart_r <= 1'b0;
      rf_r[V_A]   <= take_s(32'd65536);
      rf_r[V_B]   <= take_s(32'd13107);
      rf_r[V_C]   <= take_s(-32'sd131072);
      rf_r[V_D]   <= take_s(32'd52429);
      rf_r[V_QPP] <= take_u(31'd6554);
      rf_r[V_QPV] <= '0;
      rf_r[V_QVV] <= take_u(31'd6554);
      rf_r[V_R]   <= take_u(31'd6554);
      rf_r[V_X]   <= take_s(32'd655360);
      rf_r[V_V]   <= '0;
      rf_r[V_P00] <= take_s(32'd65536);
      rf_r[V_P01] <= '0;
      rf_r[V_P11] <= take_s(32'd65536);
      rf_r[V_ZERO] <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ph_r    <= ph_nxt;
      dsel_r  <= dsel_nxt;
      skip_r  <= skip_nxt;
      // kick a divide on entry to the divide state and between the two gains
      dstart_r <= (state_nxt == ST_DIV) && !dstart_r && !dbusy &&
                  !((state_r == ST_DIV) && dsel_r && !dstart_r);
      if (state_r == ST_DIV && !dstart_r && !dbusy && state_r == ST_DIV) begin
        if (dsel_r) rf_r[V_K1] <= quo;
        else        rf_r[V_K0] <= quo;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TPP: rf_r[V_A]   <= take_s(cfg_data);
          REG_TPV: rf_r[V_B]   <= take_s(cfg_data);
          REG_TVP: rf_r[V_C]   <= take_s(cfg_data);
          REG_TVV: rf_r[V_D]   <= take_s(cfg_data);
          REG_QPP: rf_r[V_QPP] <= take_u(cfg_data[30:0]);
          REG_QPV: rf_r[V_QPV] <= take_s(cfg_data);
          REG_QVV: rf_r[V_QVV] <= take_u(cfg_data[30:0]);
          REG_R:   rf_r[V_R]   <= take_u(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_acc) begin
        rf_r[V_Z] <= take_s(in_measurement);
        if (in_mode) begin
          rf_r[V_X]   <= take_s(in_init_pos);
          rf_r[V_V]   <= take_s(in_init_vel);
          rf_r[V_P00] <= take_u(in_init_p00);
          rf_r[V_P01] <= take_s(in_init_p01);
          rf_r[V_P11] <= take_u(in_init_p11);
        end
      end
      if (state_r == ST_MAC && ph_r && u.wr) rf_r[u.dst] <= acc;
      // skipped correction keeps the prediction
      if (state_r == ST_MAC && ph_r && pc_r == PC_PRE_DIV &&
          (rf_r[V_S][DATA_WIDTH-1] || rf_r[V_S] == '0)) begin
        rf_r[V_X]   <= rf_r[V_X0];
        rf_r[V_V]   <= rf_r[V_X1];
        rf_r[V_P00] <= rf_r[V_PP00];
        rf_r[V_P01] <= rf_r[V_PP01];
        rf_r[V_P11] <= rf_r[V_PP11];
      end
    end
  end

  assign out_est_pos      = opos_r;
  assign out_est_vel      = ovel_r;
  assign out_var_pos      = ovarp_r;
  assign out_cov_pos_vel  = ocov_r;
  assign out_var_vel      = ovarv_r;
  assign out_gain_skipped = oskip_r;

endmodule

// File: bench/kf2_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_checker
// Watches the input, configuration and result channels of the two-state
// filter, keeps its own copy of the filter state and predicts every result
// word, then compares each accepted result field by field in arrival order.
// ----------------------------------------------------------------------------
module kf2_checker import kf2_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_measurement,
  input  logic [31:0] in_init_pos,
  input  logic [31:0] in_init_vel,
  input  logic [30:0] in_init_p00,
  input  logic [31:0] in_init_p01,
  input  logic [30:0] in_init_p11,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_est_pos,
  input  logic [31:0] out_est_vel,
  input  logic [30:0] out_var_pos,
  input  logic [31:0] out_cov_pos_vel,
  input  logic [30:0] out_var_vel,
  input  logic        out_gain_skipped,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] est_pos;
    logic [31:0] est_vel;
    logic [30:0] var_pos;
    logic [31:0] cov_pos_vel;
    logic [30:0] var_vel;
    logic        gain_skipped;
  } estimate_t;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  estimate_t estimates_due[$];
  longint    coef[NUM_REGS];
  longint    pos, vel, c00, c01, c11;

  function automatic longint clampw(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clampw(p >>> FRAC_BITS);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clampw(a + b);
  endfunction

  // gain quotient, truncated toward zero, den > 0
  function automatic longint fx_div(longint num, longint den);
    longint n, q;
    n = num < 0 ? -num : num;
    q = (n <<< FRAC_BITS) / den;
    if (q > WMAX) return num < 0 ? WMIN : WMAX;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint ext_s(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint ext_u(logic [31:0] v);
    return longint'({33'd0, v[30:0]});
  endfunction

  function automatic logic [30:0] var_out(longint v);
    return v < 0 ? 31'd0 : v[30:0];
  endfunction

  task automatic filter_reset();
    coef[REG_TPP] = 65536;   coef[REG_TPV] = 13107;
    coef[REG_TVP] = -131072; coef[REG_TVV] = 52429;
    coef[REG_QPP] = 6554;    coef[REG_QPV] = 0;
    coef[REG_QVV] = 6554;    coef[REG_R]   = 6554;
    pos = 655360; vel = 0; c00 = 65536; c01 = 0; c11 = 65536;
  endtask

  task automatic filter_step(output estimate_t e);
    longint a, b, c, d, x0, x1, m00, m01, m10, m11, p00, p01, p11, s, k0, k1, inn;
    logic skip;
    skip = 1'b0;
    if (in_mode) begin
      pos = ext_s(in_init_pos); vel = ext_s(in_init_vel);
      c00 = ext_u({1'b0, in_init_p00}); c01 = ext_s(in_init_p01);
      c11 = ext_u({1'b0, in_init_p11});
    end else begin
      a = coef[REG_TPP]; b = coef[REG_TPV]; c = coef[REG_TVP]; d = coef[REG_TVV];
      x0  = fx_add(fx_mul(a, pos), fx_mul(b, vel));
      x1  = fx_add(fx_mul(c, pos), fx_mul(d, vel));
      m00 = fx_add(fx_mul(a, c00), fx_mul(b, c01));
      m01 = fx_add(fx_mul(a, c01), fx_mul(b, c11));
      m10 = fx_add(fx_mul(c, c00), fx_mul(d, c01));
      m11 = fx_add(fx_mul(c, c01), fx_mul(d, c11));
      p00 = fx_add(fx_add(fx_mul(m00, a), fx_mul(m01, b)), coef[REG_QPP]);
      p01 = fx_add(fx_add(fx_mul(m00, c), fx_mul(m01, d)), coef[REG_QPV]);
      p11 = fx_add(fx_add(fx_mul(m10, c), fx_mul(m11, d)), coef[REG_QVV]);
      s   = fx_add(p00, coef[REG_R]);
      if (s <= 0) begin
        // innovation variance not positive: keep the prediction
        skip = 1'b1;
        pos = x0; vel = x1; c00 = p00; c01 = p01; c11 = p11;
      end else begin
        k0  = fx_div(p00, s);
        k1  = fx_div(p01, s);
        inn = clampw(ext_s(in_measurement) - x0);
        pos = fx_add(x0, fx_mul(k0, inn));
        vel = fx_add(x1, fx_mul(k1, inn));
        c00 = clampw(p00 - fx_mul(k0, p00));
        c01 = clampw(p01 - fx_mul(k0, p01));
        c11 = clampw(p11 - fx_mul(k1, p01));
      end
    end
    e.est_pos      = pos[31:0];
    e.est_vel      = vel[31:0];
    e.var_pos      = var_out(c00);
    e.cov_pos_vel  = c01[31:0];
    e.var_vel      = var_out(c11);
    e.gain_skipped = skip;
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    estimate_t e, w;
    if (!rst_n) begin
      filter_reset();
      estimates_due.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_QPP || cfg_index == REG_QVV || cfg_index == REG_R)
          coef[cfg_index] = ext_u(cfg_data);
        else
          coef[cfg_index] = ext_s(cfg_data);
      end
      if (out_valid && !out_stall) begin
        if (estimates_due.size() == 0) begin
          $display("%0t result word with none expected", $realtime);
          fail_count++;
        end else begin
          w = estimates_due.pop_front();
          if (out_est_pos !== w.est_pos) report("est_pos", out_est_pos, w.est_pos);
          if (out_est_vel !== w.est_vel) report("est_vel", out_est_vel, w.est_vel);
          if (out_var_pos !== w.var_pos)
            report("var_pos", 32'(out_var_pos), 32'(w.var_pos));
          if (out_cov_pos_vel !== w.cov_pos_vel)
            report("cov_pos_vel", out_cov_pos_vel, w.cov_pos_vel);
          if (out_var_vel !== w.var_vel)
            report("var_vel", 32'(out_var_vel), 32'(w.var_vel));
          if (out_gain_skipped !== w.gain_skipped)
            report("gain_skipped", 32'(out_gain_skipped), 32'(w.gain_skipped));
        end
      end
      if (in_valid && !in_stall) begin
        filter_step(e);
        estimates_due.push_back(e);
      end
      pending = estimates_due.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the two-state Kalman filter unit: directed corner words,
// then randomised phases with fresh matrices, random idling on both sides,
// and a checker module that predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import kf2_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PHASES         = 5;
  localparam int PHASE_WORDS    = 100;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_mode;
  logic [31:0] in_measurement, in_init_pos, in_init_vel, in_init_p01;
  logic [30:0] in_init_p00, in_init_p11;
  logic        out_valid, out_stall, out_gain_skipped;
  logic [31:0] out_est_pos, out_est_vel, out_cov_pos_vel;
  logic [30:0] out_var_pos, out_var_vel;
  logic        cfg_valid, cfg_ready;
  logic [IDX_WIDTH-1:0] cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, idle_cycles;
  bit          quiet;  // no idling in the closing stretch

  kalman_filter_2state_1meas_unit dut (.*);

  kf2_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("kalman_filter_2state_1meas_unit regression: fail");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver stall: bursts of back-pressure, free-running otherwise
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_word(logic mode, logic [31:0] z, logic [31:0] p, logic [31:0] v,
                           logic [30:0] q00, logic [31:0] q01, logic [30:0] q11);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_measurement <= z;
    in_init_pos    <= p;
    in_init_vel    <= v;
    in_init_p00    <= q00;
    in_init_p01    <= q01;
    in_init_p11    <= q11;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic measure(logic [31:0] z);
    push_word(1'b0, z, $urandom, $urandom, 31'($urandom), $urandom, 31'($urandom));
  endtask

  task automatic load(logic [31:0] p, logic [31:0] v, logic [30:0] q00,
                      logic [31:0] q01, logic [30:0] q11);
    push_word(1'b1, $urandom, p, v, q00, q01, q11);
  endtask

  // Let every outstanding result drain before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_matrices(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                logic [31:0] d, logic [31:0] qpp, logic [31:0] qpv,
                                logic [31:0] qvv, logic [31:0] r);
    write_reg(REG_TPP, a);   write_reg(REG_TPV, b);
    write_reg(REG_TVP, c);   write_reg(REG_TVV, d);
    write_reg(REG_QPP, qpp); write_reg(REG_QPV, qpv);
    write_reg(REG_QVV, qvv); write_reg(REG_R, r);
    cfg_valid <= 1'b0;
  endtask

  // Small signed offset for plausible tracking values
  function automatic logic [31:0] near(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin
    in_valid = 1'b0; in_mode = 1'b0; in_measurement = '0;
    in_init_pos = '0; in_init_vel = '0; in_init_p00 = '0;
    in_init_p01 = '0; in_init_p11 = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    idle_cycles = 0; quiet = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: default matrices ---
    measure(32'd0);
    measure(32'h7fff_ffff);
    measure(32'h8000_0000);
    load(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    measure(32'h8000_0000);
    load(32'h8000_0000, 32'h8000_0000, 31'd0, 32'h8000_0000, 31'd0);
    measure(32'h7fff_ffff);
    load(32'd0, 32'd0, 31'd0, 32'd0, 31'd0);
    measure(32'd65536);
    load(32'd655360, 32'd65536, 31'd65536, 32'hffff_0000, 31'd65536);
    measure(32'd700000);
    measure(32'd720000);

    // --- innovation variance zero: correction skipped ---
    drain();
    write_matrices('0, '0, '0, '0, '0, '0, '0, '0);
    measure(32'd12345);
    load(32'd1000, 32'd2000, 31'd0, 32'd0, 31'd0);
    measure(32'd0);
    // zero innovation variance again, with a negative covariance noise term
    drain();
    write_matrices(32'd65536, '0, '0, 32'd65536, '0, 32'h8000_0000, 32'hffff_ffff, '0);
    load(32'd5, 32'd6, 31'd0, 32'd0, 31'd0);
    measure(32'd100);
    measure(32'd100);

    // --- extremes of every register ---
    drain();
    write_matrices(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    measure(32'h7fff_ffff);
    measure(32'h8000_0000);
    drain();
    write_matrices(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    load(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    measure(32'h8000_0000);
    measure(32'd0);

    // --- random phases ---
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == PHASES - 1) quiet = 1'b1;
      if (ph % 3 == 2)
        write_matrices($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      else
        // well-behaved constant-velocity model with random step and noise
        write_matrices(32'd65536 + near(4096), 32'($urandom_range(0, 32768)),
                       near(8192), 32'd65536 - 32'($urandom_range(0, 16384)),
                       32'($urandom_range(0, 65536)), near(4096),
                       32'($urandom_range(0, 65536)), 32'($urandom_range(0, 1 << 18)));
      load(near(1 << 22), near(1 << 18), 31'($urandom_range(0, 1 << 20)), near(1 << 14),
           31'($urandom_range(0, 1 << 20)));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 19))
          0, 1:    load(near(1 << 22), near(1 << 18), 31'($urandom_range(0, 1 << 20)),
                        near(1 << 16), 31'($urandom_range(0, 1 << 20)));
          2:       push_word(1'b1, $urandom, $urandom, $urandom, 31'($urandom), $urandom,
                             31'($urandom));
          3:       measure($urandom);
          default: measure(near(1 << 22));
        endcase
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("kalman_filter_2state_1meas_unit regression: pass");
    else
      $display("kalman_filter_2state_1meas_unit regression: fail");
    $finish;
  end

endmodule
